FILE: rtl/glyph_cell_matcher_defines.svh
// Assertion helpers for the glyph cell matcher.
`ifndef GLYPH_CELL_MATCHER_DEFINES_SVH
`define GLYPH_CELL_MATCHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gcm_pkg.sv
`default_nettype none

package gcm_pkg;

    localparam int NUM_GLYPHS  = 96;
    localparam int CELL_LINES  = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
    localparam int FIRST_CODE  = 32;

    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] UNKNOWN_RESET = 8'd63;

    // action codes
    localparam logic [1:0] ACT_LOAD     = 2'd0;
    localparam logic [1:0] ACT_CLASSIFY = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    // match kinds
    localparam logic [1:0] KIND_BLANK   = 2'd0;
    localparam logic [1:0] KIND_RECOG   = 2'd1;
    localparam logic [1:0] KIND_INVERSE = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // register index (byte address bit 2)
    localparam logic REG_DETECT_INV = 1'b0;
    localparam logic REG_UNKNOWN    = 1'b1;

    typedef struct packed {
        logic [1:0]                  action;
        logic [6:0]                  glyph_index;
        logic [CELL_LINES*8-1:0]     pattern;
    } item_t;

    typedef struct packed {
        logic [7:0]  char_code;
        logic [1:0]  match_kind;
        logic [15:0] blank_count;
        logic [15:0] recognised_count;
        logic [15:0] inverse_count;
        logic [15:0] unknown_count;
    } result_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (&v) ? v : COUNT_WIDTH'(v + 1'b1);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/glyph_cell_matcher.sv
// glyph_cell_matcher: exact-match recognizer for 8x8 character cells.
// Item channel (item_valid/item_stall/item): one transaction carries an
//   action (load glyph, classify cell, clear counters), a glyph slot and
//   a 64-bit pattern, line i in bits 8i+7..8i.
// Result channel (result_valid/result_stall/result): one transaction per
//   classify, with the character code, the match kind and the four class
//   counters as they stand after that cell. Load and clear give none.
// Flow: load and clear leave the sequencer idle, so a new transaction may
//   follow at once. A blank cell goes straight to the done state and then
//   to the output register. A non-blank cell walks the font slot by slot,
//   each slot taking a fetch state (one registered read of the single glyph
//   RAM read port) and a compare state (against the glyph and, if enabled,
//   its inverse); the first hit ends the walk, else the last slot does.
// item_stall is high while a classify is in flight or its result waits
//   for the output register to free up; a stalled result holds its value.
// Reset clears control state, the counters and the config registers
//   (inverse match enable = 0, unknown_char = 63). The font RAM is not
//   cleared and must be loaded before classifying.
// APB port: inverse enable at 0x0, unknown_char at 0x4, pready tied high.

`default_nettype none

module glyph_cell_matcher (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire gcm_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output gcm_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import gcm_pkg::*;

    `include "glyph_cell_matcher_defines.svh"

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [63:0]  cell_reg, cell_next;
    logic [63:0]  rd_data_reg;
    logic [7:0]   code_reg, code_next;
    logic [1:0]   kind_reg, kind_next;

    logic         detect_inv_reg;
    logic [7:0]   unknown_char_reg;

    count_t       blank_reg, recog_reg, inv_reg, unk_reg;

    logic [63:0]  glyph_mem [NUM_GLYPHS];

    logic         item_acc;
    logic         cfg_wr;
    logic         out_free;
    logic         finish;
    logic         load_wr;
    logic         hit_direct, hit_inverse;

    assign item_acc   = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign out_free   = !result_valid || !result_stall;
    assign finish     = (state_reg == S_DONE) && out_free;
    assign load_wr    = item_acc && (item.action == ACT_LOAD)
                        && ({2'b00, item.glyph_index} < 9'(NUM_GLYPHS));

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_inv_reg   <= 1'b0;
            unknown_char_reg <= UNKNOWN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_DETECT_INV: detect_inv_reg   <= pwdata[0];
                REG_UNKNOWN:    unknown_char_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DETECT_INV: prdata = {31'd0, detect_inv_reg};
            REG_UNKNOWN:    prdata = {24'd0, unknown_char_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---- font RAM: one write port, one registered read port ----
    always_ff @(posedge clk)
    begin
        if (load_wr)
            glyph_mem[IDX_W'(item.glyph_index)] <= item.pattern;
        if (state_reg == S_FETCH)
            rd_data_reg <= glyph_mem[ptr_reg];
    end

    // shared compare unit: cell against glyph and its inverse
    assign hit_direct  = (cell_reg == rd_data_reg);
    assign hit_inverse = detect_inv_reg && (cell_reg == ~rd_data_reg);

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        cell_next  = cell_reg;
        code_next  = code_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc && (item.action == ACT_CLASSIFY))
                begin
                    cell_next = item.pattern;
                    ptr_next  = '0;
                    if (item.pattern == 64'd0)
                    begin
                        code_next  = SPACE_CODE;
                        kind_next  = KIND_BLANK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit_direct || hit_inverse)
                begin
                    code_next  = 8'(FIRST_CODE + 32'(ptr_reg));
                    kind_next  = hit_direct ? KIND_RECOG : KIND_INVERSE;
                    state_next = S_DONE;
                end
                else if (ptr_reg == IDX_W'(NUM_GLYPHS - 1))
                begin
                    code_next  = unknown_char_reg;
                    kind_next  = KIND_UNKNOWN;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = IDX_W'(ptr_reg + 1'b1);
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        code_reg <= code_next;
        kind_reg <= kind_next;
    end

    // ---- class counters ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_reg <= '0;
            recog_reg <= '0;
            inv_reg   <= '0;
            unk_reg   <= '0;
        end
        else if (item_acc && (item.action == ACT_CLEAR))
        begin
            blank_reg <= '0;
            recog_reg <= '0;
            inv_reg   <= '0;
            unk_reg   <= '0;
        end
        else if (finish)
        begin
            case (kind_reg)
                KIND_BLANK:   blank_reg <= sat_inc(blank_reg);
                KIND_RECOG:   recog_reg <= sat_inc(recog_reg);
                KIND_INVERSE: inv_reg   <= sat_inc(inv_reg);
                default:      unk_reg   <= sat_inc(unk_reg);
            endcase
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (finish)
            result_valid <= 1'b1;
        else if (!result_stall)
            result_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result.char_code        <= code_reg;
            result.match_kind       <= kind_reg;
            result.blank_count      <= 16'((kind_reg == KIND_BLANK)   ? sat_inc(blank_reg)
                                                                      : blank_reg);
            result.recognised_count <= 16'((kind_reg == KIND_RECOG)   ? sat_inc(recog_reg)
                                                                      : recog_reg);
            result.inverse_count    <= 16'((kind_reg == KIND_INVERSE) ? sat_inc(inv_reg)
                                                                      : inv_reg);
            result.unknown_count    <= 16'((kind_reg == KIND_UNKNOWN) ? sat_inc(unk_reg)
                                                                      : unk_reg);
        end
    end

    // ---- assertions ----
    `GCM_ASSERT_NEXT(a_finish_shows_result, finish, result_valid, "finished cell not presented")
    `GCM_ASSERT_NOW(a_ptr_in_range, state_reg != S_IDLE, 9'(ptr_reg) < 9'(NUM_GLYPHS), "scan pointer past font")
    `GCM_ASSERT_NOW(a_blank_is_space, result_valid && result.match_kind == KIND_BLANK, result.char_code == SPACE_CODE, "blank cell without space code")

endmodule

`default_nettype wire
